@@ rtl/iau_pkg.sv @@
// ----------------------------------------------------------------------------
// Interval arithmetic unit package
// Shared widths, codes, pipeline types and helper functions.
// ----------------------------------------------------------------------------
package iau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;             // endpoint width
  localparam int NW        = DW + FRAC_BITS; // dividend magnitude width
  localparam int XW        = 2 * DW + 2;     // working width of rounded values

  localparam logic [1:0] CMD_MUL   = 2'd0;
  localparam logic [1:0] CMD_DIV   = 2'd1;
  localparam logic [1:0] CMD_HULL  = 2'd2;
  localparam logic [1:0] CMD_POINT = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DZ   = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef struct packed {
    logic [NW-1:0] nq;   // dividend bits, replaced by quotient bits as they form
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic          neg;  // exact quotient is negative
  } lane_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic                   dz;
    logic signed [2*DW-1:0] p0;
    logic signed [2*DW-1:0] p1;
    logic signed [2*DW-1:0] p2;
    logic signed [2*DW-1:0] p3;
    logic signed [DW-1:0]   h_lo;
    logic signed [DW-1:0]   h_hi;
    lane_t [3:0]            ln;
  } item_t;

  function automatic logic signed [XW-1:0] smin(input logic signed [XW-1:0] x,
                                                input logic signed [XW-1:0] y);
    smin = (x < y) ? x : y;
  endfunction

  function automatic logic signed [XW-1:0] smax(input logic signed [XW-1:0] x,
                                                input logic signed [XW-1:0] y);
    smax = (x > y) ? x : y;
  endfunction

endpackage

@@ rtl/iau_front.sv @@
// ----------------------------------------------------------------------------
// Interval unit front end
// Registers the operands, forms the endpoint products, divider operands,
// zero-divisor flag and hull endpoints.
// ----------------------------------------------------------------------------
module iau_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [1:0]                 cmd,
  input  logic signed [iau_pkg::DW-1:0] a_lo,
  input  logic signed [iau_pkg::DW-1:0] a_hi,
  input  logic signed [iau_pkg::DW-1:0] b_lo,
  input  logic signed [iau_pkg::DW-1:0] b_hi,
  input  logic signed [iau_pkg::DW-1:0] point_value,
  output logic                       out_valid,
  output iau_pkg::item_t             out_item
);

  logic                          v1;
  logic [1:0]                    cmd1;
  logic signed [iau_pkg::DW-1:0] al1, ah1, bl1, bh1, pv1;
  iau_pkg::item_t                item_next;

  function automatic logic [iau_pkg::DW-1:0] mag(input logic signed [iau_pkg::DW-1:0] x);
    mag = x[iau_pkg::DW-1] ? (iau_pkg::DW'(0) - x) : x;
  endfunction

  function automatic iau_pkg::lane_t mk_lane(input logic signed [iau_pkg::DW-1:0] n,
                                             input logic signed [iau_pkg::DW-1:0] d);
    iau_pkg::lane_t l;
    l.nq  = {mag(n), {iau_pkg::FRAC_BITS{1'b0}}};
    l.rem = '0;
    l.den = mag(d);
    l.neg = (n != '0) && (n[iau_pkg::DW-1] ^ d[iau_pkg::DW-1]);
    mk_lane = l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      cmd1 <= cmd;
      al1  <= a_lo;
      ah1  <= a_hi;
      bl1  <= b_lo;
      bh1  <= b_hi;
      pv1  <= point_value;
    end
  end

  always_comb begin
    item_next.cmd = cmd1;
    item_next.dz  = !(((bl1 > 0) && (bh1 > 0)) || ((bl1 < 0) && (bh1 < 0)));
    item_next.p0  = al1 * bl1;
    item_next.p1  = al1 * bh1;
    item_next.p2  = ah1 * bl1;
    item_next.p3  = ah1 * bh1;
    if (cmd1 == iau_pkg::CMD_POINT) begin
      item_next.h_lo = (al1 < pv1) ? al1 : pv1;
      item_next.h_hi = (ah1 > pv1) ? ah1 : pv1;
    end else begin
      item_next.h_lo = (al1 < bl1) ? al1 : bl1;
      item_next.h_hi = (ah1 > bh1) ? ah1 : bh1;
    end
    item_next.ln[0] = mk_lane(al1, bl1);
    item_next.ln[1] = mk_lane(al1, bh1);
    item_next.ln[2] = mk_lane(ah1, bl1);
    item_next.ln[3] = mk_lane(ah1, bh1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/iau_div_stage.sv @@
// ----------------------------------------------------------------------------
// Divider stage
// One restoring quotient bit for each of the four lanes; the rest of the
// word rides along unchanged.
// ----------------------------------------------------------------------------
module iau_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  iau_pkg::item_t in_item,
  output logic           out_valid,
  output iau_pkg::item_t out_item
);

  iau_pkg::item_t item_next;
  logic [iau_pkg::DW:0] r2   [4];
  logic [iau_pkg::DW:0] diff [4];
  logic                 ge   [4];

  always_comb begin
    item_next = in_item;
    for (int k = 0; k < 4; k++) begin
      r2[k]   = {in_item.ln[k].rem, in_item.ln[k].nq[iau_pkg::NW-1]};
      diff[k] = r2[k] - {1'b0, in_item.ln[k].den};
      ge[k]   = r2[k] >= {1'b0, in_item.ln[k].den};
      item_next.ln[k].rem = ge[k] ? diff[k][iau_pkg::DW-1:0] : r2[k][iau_pkg::DW-1:0];
      item_next.ln[k].nq  = {in_item.ln[k].nq[iau_pkg::NW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/iau_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined divider
// A chain of single-bit stages, one per dividend bit.
// ----------------------------------------------------------------------------
module iau_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  iau_pkg::item_t in_item,
  output logic           out_valid,
  output iau_pkg::item_t out_item
);

  logic           vld [iau_pkg::NW+1];
  iau_pkg::item_t st  [iau_pkg::NW+1];

  assign vld[0] = in_valid;
  assign st[0]  = in_item;

  for (genvar i = 0; i < iau_pkg::NW; i++) begin : g_stage
    iau_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_item   (st[i]),
      .out_valid (vld[i+1]),
      .out_item  (st[i+1])
    );
  end

  assign out_valid = vld[iau_pkg::NW];
  assign out_item  = st[iau_pkg::NW];

endmodule

@@ rtl/iau_back.sv @@
// ----------------------------------------------------------------------------
// Interval unit back end
// Directed rounding of products and quotients, min/max selection, then
// saturation and result selection into the output register.
// ----------------------------------------------------------------------------
module iau_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  iau_pkg::item_t         in_item,
  output logic                   out_valid,
  output logic [iau_pkg::DW-1:0] res_lo,
  output logic [iau_pkg::DW-1:0] res_hi,
  output logic [1:0]             status
);

  localparam logic [iau_pkg::XW-1:0] RND = iau_pkg::XW'((64'd1 << iau_pkg::FRAC_BITS) - 64'd1);

  logic signed [iau_pkg::XW-1:0] mf [4], mc [4], df [4], dc [4];
  logic signed [iau_pkg::XW-1:0] mf_r [4], mc_r [4], df_r [4], dc_r [4];
  logic signed [iau_pkg::XW-1:0] pe [4];
  logic [iau_pkg::XW-1:0]        qx, nzx;
  logic                          va, vb;
  logic [1:0]                    cmd_a, cmd_b;
  logic                          dz_a, dz_b;
  logic signed [iau_pkg::DW-1:0] hlo_a, hhi_a, hlo_b, hhi_b;
  logic signed [iau_pkg::XW-1:0] lo_b, hi_b;
  logic signed [iau_pkg::XW-1:0] lo_sel, hi_sel;
  logic                          sat_lo, sat_hi;
  logic [iau_pkg::DW-1:0]        lo_c, hi_c;

  // stage A: round each product and quotient toward minus and plus infinity
  always_comb begin
    pe[0] = iau_pkg::XW'(in_item.p0);
    pe[1] = iau_pkg::XW'(in_item.p1);
    pe[2] = iau_pkg::XW'(in_item.p2);
    pe[3] = iau_pkg::XW'(in_item.p3);
    qx    = '0;
    nzx   = '0;
    for (int k = 0; k < 4; k++) begin
      mf[k] = pe[k] >>> iau_pkg::FRAC_BITS;
      mc[k] = (pe[k] + $signed(RND)) >>> iau_pkg::FRAC_BITS;
      qx    = {{(iau_pkg::XW-iau_pkg::NW){1'b0}}, in_item.ln[k].nq};
      nzx   = {{(iau_pkg::XW-1){1'b0}}, (in_item.ln[k].rem != '0)};
      if (in_item.ln[k].neg) begin
        df[k] = $signed(-qx - nzx);
        dc[k] = $signed(-qx);
      end else begin
        df[k] = $signed(qx);
        dc[k] = $signed(qx + nzx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      mf_r  <= mf;
      mc_r  <= mc;
      df_r  <= df;
      dc_r  <= dc;
      cmd_a <= in_item.cmd;
      dz_a  <= in_item.dz;
      hlo_a <= in_item.h_lo;
      hhi_a <= in_item.h_hi;
    end
  end

  // stage B: bounds over the four combinations
  always_comb begin
    if (cmd_a == iau_pkg::CMD_DIV) begin
      lo_sel = iau_pkg::smin(iau_pkg::smin(df_r[0], df_r[1]), iau_pkg::smin(df_r[2], df_r[3]));
      hi_sel = iau_pkg::smax(iau_pkg::smax(dc_r[0], dc_r[1]), iau_pkg::smax(dc_r[2], dc_r[3]));
    end else begin
      lo_sel = iau_pkg::smin(iau_pkg::smin(mf_r[0], mf_r[1]), iau_pkg::smin(mf_r[2], mf_r[3]));
      hi_sel = iau_pkg::smax(iau_pkg::smax(mc_r[0], mc_r[1]), iau_pkg::smax(mc_r[2], mc_r[3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      lo_b  <= lo_sel;
      hi_b  <= hi_sel;
      cmd_b <= cmd_a;
      dz_b  <= dz_a;
      hlo_b <= hlo_a;
      hhi_b <= hhi_a;
    end
  end

  // saturate when the bits above the sign do not all match it
  always_comb begin
    sat_lo = !((&lo_b[iau_pkg::XW-1:iau_pkg::DW-1]) || !(|lo_b[iau_pkg::XW-1:iau_pkg::DW-1]));
    sat_hi = !((&hi_b[iau_pkg::XW-1:iau_pkg::DW-1]) || !(|hi_b[iau_pkg::XW-1:iau_pkg::DW-1]));
    lo_c   = sat_lo ? {lo_b[iau_pkg::XW-1], {(iau_pkg::DW-1){~lo_b[iau_pkg::XW-1]}}}
                    : lo_b[iau_pkg::DW-1:0];
    hi_c   = sat_hi ? {hi_b[iau_pkg::XW-1], {(iau_pkg::DW-1){~hi_b[iau_pkg::XW-1]}}}
                    : hi_b[iau_pkg::DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
    if (en) begin
      if (cmd_b == iau_pkg::CMD_HULL || cmd_b == iau_pkg::CMD_POINT) begin
        res_lo <= hlo_b;
        res_hi <= hhi_b;
        status <= iau_pkg::STAT_OK;
      end else if (cmd_b == iau_pkg::CMD_DIV && dz_b) begin
        res_lo <= '0;
        res_hi <= '0;
        status <= iau_pkg::STAT_DZ;
      end else begin
        res_lo <= lo_c;
        res_hi <= hi_c;
        status <= (sat_lo || sat_hi) ? iau_pkg::STAT_SAT : iau_pkg::STAT_OK;
      end
    end
  end

endmodule

@@ rtl/interval_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Interval arithmetic unit
// Multiply, divide and hull on signed fixed-point intervals, fully pipelined.
//
//   channel  direction  contents
//   s_*      in         tuser: cmd; tdata: a_lo, a_hi, b_lo, b_hi, point_value
//   m_*      out        tdata: res_lo, res_hi, status
//
// One word accepted per cycle while the output is not stalled; the pipe runs
// through the front end, the bit-per-stage divider chain and the back end.
// Reset clears only the valid bits along the pipe.
// A stalled output freezes the whole pipe; s_tready follows that stall.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // a_lo, a_hi, b_lo, b_hi, point_value
  input  logic [1:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata    // res_lo, res_hi, status, zero pad
);

  logic                   en;
  logic                   f_valid, d_valid;
  iau_pkg::item_t         f_item, d_item;
  logic [iau_pkg::DW-1:0] res_lo, res_hi;
  logic [1:0]             status;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  iau_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .cmd         (s_tuser),
    .a_lo        (s_tdata[31:0]),
    .a_hi        (s_tdata[63:32]),
    .b_lo        (s_tdata[95:64]),
    .b_hi        (s_tdata[127:96]),
    .point_value (s_tdata[159:128]),
    .out_valid   (f_valid),
    .out_item    (f_item)
  );

  iau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .out_valid (d_valid),
    .out_item  (d_item)
  );

  iau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_item   (d_item),
    .out_valid (m_tvalid),
    .res_lo    (res_lo),
    .res_hi    (res_hi),
    .status    (status)
  );

  assign m_tdata = {6'd0, status, res_hi, res_lo};

endmodule
